/* src/adpcm_nibble_decoder_8bit_defines.svh */
// Assertion macros for the ADPCM nibble decoder checker.
// Each macro expects clk in the scope where it is used; ADPCM8_ASSERT also expects rst_n.
`ifndef ADPCM_NIBBLE_DECODER_8BIT_DEFINES_SVH
`define ADPCM_NIBBLE_DECODER_8BIT_DEFINES_SVH

// Check a property only while out of reset.
`define ADPCM8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define ADPCM8_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/adpcm8_pkg.sv */
// Shared types, constants and tables for the IMA ADPCM nibble decoder.
// No dependencies; used by every RTL module and the checker.
`timescale 1ns / 1ps

package adpcm8_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_LAST   = 88;
  localparam int POS_W       = 7;
  localparam int STEP_W      = 15;
  localparam int PRED_W      = 16;
  localparam int CODE_W      = 4;
  localparam int BYTE_W      = 8;

  // One accepted byte, split into its two codes.
  typedef struct packed {
    logic [CODE_W-1:0] code_lo;
    logic [CODE_W-1:0] code_hi;
    logic              clear;
    logic              lo_only;
  } adpcm8_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } adpcm8_qstat_t;

  function automatic logic [STEP_W-1:0] step_size(input logic [POS_W-1:0] pos);
    logic [STEP_W-1:0] s;
    unique case (pos)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [POS_W:0] index_adj(input logic [2:0] mag);
    logic signed [POS_W:0] a;
    unique case (mag)
      3'd4:    a = 8'sd2;
      3'd5:    a = 8'sd4;
      3'd6:    a = 8'sd6;
      3'd7:    a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

/* src/adpcm8_front.sv */
// Input stage: registers an accepted byte, splits it into codes and flags.
// Depends on adpcm8_pkg; feeds adpcm8_queue.
`timescale 1ns / 1ps

module adpcm8_front import adpcm8_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_code_byte,
  input  logic               in_begin_req,
  input  logic               in_low_only,
  input  adpcm8_qstat_t      q_stat,
  output logic               q_push,
  output adpcm8_item_t       q_item
);

  logic         valid_r, valid_nxt;
  adpcm8_item_t item_r;
  logic         take;

  assign q_push   = valid_r && !q_stat.full;
  assign take     = !valid_r || q_push;
  assign in_stall = !take;
  assign q_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && take) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && take) begin
      item_r.code_lo <= in_code_byte[CODE_W-1:0];
      item_r.code_hi <= in_code_byte[BYTE_W-1:CODE_W];
      item_r.clear   <= in_begin_req;
      item_r.lo_only <= in_low_only;
    end
  end

endmodule

/* src/adpcm8_queue.sv */
// Short FIFO of split bytes between the input stage and the decode core.
// Depends on adpcm8_pkg.
`timescale 1ns / 1ps

module adpcm8_queue import adpcm8_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  adpcm8_item_t  push_item,
  input  logic          pop,
  output adpcm8_item_t  head_item,
  output adpcm8_qstat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  adpcm8_item_t    mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/adpcm8_core.sv */
// Decode core: a code per cycle unless stalled; predictor, step position update.
// Depends on adpcm8_pkg; takes items from adpcm8_queue, drives the output word.
`timescale 1ns / 1ps

module adpcm8_core import adpcm8_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  adpcm8_item_t       head_item,
  input  adpcm8_qstat_t      q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_sample,
  output logic               out_last
);

  typedef enum logic {PH_LO, PH_HI} phase_t;

  phase_t                    phase_r, phase_nxt;
  logic                      out_valid_r;
  logic [BYTE_W-1:0]         sample_r;
  logic                      last_r;
  logic signed [PRED_W-1:0]  pred_r, pred_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;

  logic                      adv, fire, last_nxt;
  logic [CODE_W-1:0]         code;
  logic signed [PRED_W-1:0]  base_pred;
  logic [POS_W-1:0]          base_pos, pos_eff;
  logic [STEP_W-1:0]         step;
  logic [STEP_W+1:0]         diff;
  logic signed [STEP_W+2:0]  sdiff, sum;
  logic signed [POS_W:0]     npos;

  assign adv  = !out_valid_r || !out_stall;
  assign fire = adv && !q_stat.empty;

  always_comb begin
    code      = (phase_r == PH_LO) ? head_item.code_lo : head_item.code_hi;
    // Begin flag resets state ahead of the low code only.
    if (phase_r == PH_LO && head_item.clear) begin
      base_pred = '0;
      base_pos  = '0;
    end else begin
      base_pred = pred_r;
      base_pos  = pos_r;
    end
    pos_eff = (base_pos > POS_W'(STEP_LAST)) ? POS_W'(STEP_LAST) : base_pos;
    step    = step_size(pos_eff);

    diff = {5'b00000, step[STEP_W-1:3]};
    if (code[0]) diff = diff + {4'b0000, step[STEP_W-1:2]};
    if (code[1]) diff = diff + {3'b000, step[STEP_W-1:1]};
    if (code[2]) diff = diff + {2'b00, step};
    sdiff = code[3] ? -$signed({1'b0, diff}) : $signed({1'b0, diff});
    sum   = $signed({{2{base_pred[PRED_W-1]}}, base_pred}) + sdiff;

    // Saturate to the signed 16-bit range.
    if (sum[STEP_W+2:PRED_W-1] == '0 || sum[STEP_W+2:PRED_W-1] == '1) begin
      pred_nxt = sum[PRED_W-1:0];
    end else if (sum[STEP_W+2]) begin
      pred_nxt = {1'b1, {(PRED_W-1){1'b0}}};
    end else begin
      pred_nxt = {1'b0, {(PRED_W-1){1'b1}}};
    end

    npos = $signed({1'b0, pos_eff}) + index_adj(code[2:0]);
    if (npos < 0) begin
      pos_nxt = '0;
    end else if (npos > $signed((POS_W+1)'(STEP_LAST))) begin
      pos_nxt = POS_W'(STEP_LAST);
    end else begin
      pos_nxt = npos[POS_W-1:0];
    end

    last_nxt  = (phase_r == PH_HI) || head_item.lo_only;
    phase_nxt = last_nxt ? PH_LO : PH_HI;
  end

  assign q_pop      = fire && last_nxt;
  assign out_valid  = out_valid_r;
  assign out_sample = sample_r;
  assign out_last   = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LO;
      out_valid_r <= 1'b0;
      pred_r      <= '0;
      pos_r       <= '0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      out_valid_r <= 1'b1;
      pred_r      <= pred_nxt;
      pos_r       <= pos_nxt;
    end else if (adv) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      sample_r <= pred_nxt[PRED_W-1:PRED_W-BYTE_W] ^ 8'h80;
      last_r   <= last_nxt;
    end
  end

endmodule

/* src/adpcm_nibble_decoder_8bit.sv */
// Channel   Ports                                       Word
// in        in_valid / in_stall                          code byte, begin, low-only flags
// out       out_valid / out_stall                        unsigned 8-bit sample, last flag
//
// The decode core takes each byte one code at a time, low code first, then high code;
// a low-only byte gives its low code only.
// Input register and queue let new bytes enter while the core works or the output stalls.
// First sample passes the input register, the queue and the core output register.
// Synchronous active-low reset clears predictor, step position and all valid state.
// Depends on adpcm8_pkg, adpcm8_front, adpcm8_queue, adpcm8_core.
`timescale 1ns / 1ps

module adpcm_nibble_decoder_8bit import adpcm8_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_code_byte,
  input  logic               in_begin_req,
  input  logic               in_low_only,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_sample,
  output logic               out_last
);

  adpcm8_item_t  push_item, head_item;
  adpcm8_qstat_t q_stat;
  logic          q_push, q_pop;

  adpcm8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_byte (in_code_byte),
    .in_begin_req (in_begin_req),
    .in_low_only  (in_low_only),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  adpcm8_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  adpcm8_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule

/* src/adpcm8_checker.sv */
// Port-level checker for the ADPCM nibble decoder, bound to the top level.
// Depends on adpcm8_pkg and adpcm_nibble_decoder_8bit_defines.svh.
`timescale 1ns / 1ps
`include "adpcm_nibble_decoder_8bit_defines.svh"

module adpcm8_checker import adpcm8_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [BYTE_W-1:0]  in_code_byte,
  input logic               in_begin_req,
  input logic               in_low_only,
  input logic               out_valid,
  input logic               out_stall,
  input logic [BYTE_W-1:0]  out_sample,
  input logic               out_last
);

  logic [7:0] pending_r, pending_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Count samples owed for accepted words.
  always_comb begin
    pending_nxt = pending_r;
    if (in_acc) pending_nxt = pending_nxt + (in_low_only ? 8'd1 : 8'd2);
    if (out_acc) pending_nxt = pending_nxt - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `ADPCM8_ASSERT(a_no_spurious, out_valid |-> pending_r != 8'd0, "sample with no owed word")
  `ADPCM8_ASSERT(a_pair_owed, (out_acc && !out_last) |-> pending_r >= 8'd2,
    "non-last sample without its partner owed")
  `ADPCM8_ASSERT(a_hold, (out_valid && out_stall) |=>
    (out_valid && $stable(out_sample) && $stable(out_last)), "stalled output changed")
  `ADPCM8_ASSERT(a_in_hold, (in_valid && in_stall) |=> (in_valid && $stable(in_code_byte)
    && $stable(in_begin_req) && $stable(in_low_only)), "stalled input changed")
  `ADPCM8_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind adpcm_nibble_decoder_8bit adpcm8_checker u_adpcm8_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_code_byte (in_code_byte),
  .in_begin_req (in_begin_req),
  .in_low_only  (in_low_only),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_sample   (out_sample),
  .out_last     (out_last)
);
